// ----- hdl/gsp_pkg.sv -----
// Package for the grid shortest path block: sizes, codes and payload types.
// Used by grid_shortest_path; depends on nothing else.
package gsp_pkg;
	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 64;
	localparam int COST_BITS = 4;
	localparam int ROW_W     = 5;
	localparam int COL_W     = 6;
	localparam int IDX_W     = ROW_W + COL_W;
	localparam int CELLS     = MAX_ROWS * MAX_COLS;
	localparam int DIST_W    = 15;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_RUN  = 2'd1;
	localparam logic [1:0] ACT_PATH = 2'd2;

	localparam logic [2:0] DIR_NONE  = 3'd0;
	localparam logic [2:0] DIR_NORTH = 3'd1;
	localparam logic [2:0] DIR_EAST  = 3'd2;
	localparam logic [2:0] DIR_SOUTH = 3'd3;
	localparam logic [2:0] DIR_WEST  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_COL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_ROW   = 3'd5;

	localparam logic RES_SEARCH = 1'b0;
	localparam logic RES_PATH   = 1'b1;

	typedef struct packed {
		logic [1:0]           action;
		logic [IDX_W-1:0]     cell_index;
		logic [COST_BITS-1:0] cell_cost;
	} cmd_t;

	typedef struct packed {
		logic              result_kind;
		logic [DIST_W-1:0] total_cost;
		logic [COL_W-1:0]  path_col;
		logic [ROW_W-1:0]  path_row;
		logic              last_cell;
	} res_t;

	typedef struct packed {
		logic              visited;
		logic [DIST_W-1:0] distance;
		logic [2:0]        parent;
	} node_t;
endpackage

// ----- hdl/gsp_ram.sv -----
// Generic single-port RAM with one access per cycle (a read, plus a write when we is set) and registered read data.
// Depends on nothing.
module gsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- hdl/grid_shortest_path.sv -----
// Top level of the grid shortest path block: sequencer, registers and two RAMs.
// Depends on gsp_pkg and gsp_ram.
//
// A run first clears all 2048 node RAM entries and writes the start cell, then settles
// one cell at a time: each settle scans every cell in use through the single node RAM
// port, then marks the chosen cell and updates its neighbours inside the grid. The
// block takes the next command while a result still waits for its transfer.
module grid_shortest_path
	import gsp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLR   = 4'd1;
	localparam logic [3:0] ST_SRC   = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_SCANW = 4'd4;
	localparam logic [3:0] ST_MARK  = 4'd5;
	localparam logic [3:0] ST_NBRD  = 4'd6;
	localparam logic [3:0] ST_NBWR  = 4'd7;
	localparam logic [3:0] ST_FINRD = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_PRD   = 4'd10;
	localparam logic [3:0] ST_POUT  = 4'd11;

	logic [3:0]       state_q;
	logic [5:0]       grid_rows_q;
	logic [6:0]       grid_cols_q;
	logic [COL_W-1:0] start_col_q, end_col_q;
	logic [ROW_W-1:0] start_row_q, end_row_q;

	logic [IDX_W-1:0]  clr_q, best_q, addr_s1, cursor_q;
	logic [ROW_W-1:0]  sr_q;
	logic [COL_W-1:0]  sc_q;
	logic [DIST_W:0]   bd_q;
	logic [2:0]        bpar_q;
	logic              found_q, v_s1, path_done_q;
	logic [1:0]        nb_q;
	logic              res_valid_q;
	res_t              res_q;

	logic [5:0]           rows;
	logic [6:0]           cols;
	logic [ROW_W-1:0]     src_r, dst_r, br;
	logic [COL_W-1:0]     src_c, dst_c, bc;
	logic [IDX_W-1:0]     src, dst;
	logic                 accept, slot_free, take, scan_last;
	logic                 nb_ok;
	logic [IDX_W-1:0]     nb_addr;
	logic [2:0]           nb_dir;
	logic [DIST_W:0]      sum;
	logic [DIST_W-1:0]    dsat;
	logic                 node_we, cost_we;
	logic [IDX_W-1:0]     node_addr, cost_addr;
	node_t                node_wd, node_rd;
	logic [COST_BITS-1:0] cost_rd;
	logic [ROW_W-1:0]     pr;
	logic [COL_W-1:0]     pc;

	gsp_ram #(.WIDTH($bits(node_t)), .DEPTH(CELLS)) u_node_ram (
		.clk(clk), .we(node_we), .addr(node_addr), .wdata(node_wd), .rdata(node_rd)
	);

	gsp_ram #(.WIDTH(COST_BITS), .DEPTH(CELLS)) u_cost_ram (
		.clk(clk), .we(cost_we), .addr(cost_addr), .wdata(cmd.cell_cost), .rdata(cost_rd)
	);

	always_comb begin
		if (grid_rows_q == '0) begin
			rows = 6'd1;
		end else if (grid_rows_q > 6'(MAX_ROWS)) begin
			rows = 6'(MAX_ROWS);
		end else begin
			rows = grid_rows_q;
		end
		if (grid_cols_q == '0) begin
			cols = 7'd1;
		end else if (grid_cols_q > 7'(MAX_COLS)) begin
			cols = 7'(MAX_COLS);
		end else begin
			cols = grid_cols_q;
		end
		src_r = ({1'b0, start_row_q} >= rows) ? ROW_W'(rows - 6'd1) : start_row_q;
		dst_r = ({1'b0, end_row_q} >= rows) ? ROW_W'(rows - 6'd1) : end_row_q;
		src_c = ({1'b0, start_col_q} >= cols) ? COL_W'(cols - 7'd1) : start_col_q;
		dst_c = ({1'b0, end_col_q} >= cols) ? COL_W'(cols - 7'd1) : end_col_q;
		src = {src_r, src_c};
		dst = {dst_r, dst_c};
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign slot_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign take = v_s1 && !node_rd.visited && ({1'b0, node_rd.distance} < bd_q);
	assign scan_last = ({1'b0, sr_q} == rows - 6'd1) && ({1'b0, sc_q} == cols - 7'd1);

	assign br = best_q[IDX_W-1:COL_W];
	assign bc = best_q[COL_W-1:0];

	always_comb begin
		unique case (nb_q)
			2'd0: begin
				nb_ok = (br != '0);
				nb_addr = best_q - IDX_W'(MAX_COLS);
				nb_dir = DIR_SOUTH;
			end
			2'd1: begin
				nb_ok = ({1'b0, bc} + 7'd1) < cols;
				nb_addr = best_q + IDX_W'(1);
				nb_dir = DIR_WEST;
			end
			2'd2: begin
				nb_ok = ({1'b0, br} + 6'd1) < rows;
				nb_addr = best_q + IDX_W'(MAX_COLS);
				nb_dir = DIR_NORTH;
			end
			default: begin
				nb_ok = (bc != '0);
				nb_addr = best_q - IDX_W'(1);
				nb_dir = DIR_EAST;
			end
		endcase
		sum = {1'b0, bd_q[DIST_W-1:0]} + (DIST_W+1)'(cost_rd);
		dsat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	end

	assign pr = cursor_q[IDX_W-1:COL_W];
	assign pc = cursor_q[COL_W-1:0];

	always_comb begin
		node_we = 1'b0;
		node_addr = best_q;
		node_wd = node_t'{visited: 1'b0, distance: DIST_MAX, parent: DIR_NONE};
		unique case (state_q)
			ST_CLR: begin
				node_we = 1'b1;
				node_addr = clr_q;
			end
			ST_SRC: begin
				node_we = 1'b1;
				node_addr = src;
				node_wd = node_t'{visited: 1'b0, distance: '0, parent: DIR_NONE};
			end
			ST_SCAN: node_addr = {sr_q, sc_q};
			ST_MARK: begin
				node_we = 1'b1;
				node_wd = node_t'{visited: 1'b1, distance: bd_q[DIST_W-1:0], parent: bpar_q};
			end
			ST_NBRD: node_addr = nb_addr;
			ST_NBWR: begin
				node_addr = nb_addr;
				node_we = (dsat < node_rd.distance);
				node_wd = node_t'{visited: node_rd.visited, distance: dsat, parent: nb_dir};
			end
			ST_FINRD, ST_FIN: node_addr = dst;
			ST_PRD, ST_POUT: node_addr = cursor_q;
			default: node_addr = best_q;
		endcase
		cost_we = accept && (cmd.action == ACT_LOAD);
		cost_addr = cost_we ? cmd.cell_index : node_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= 6'd20;
			grid_cols_q <= 7'd40;
			start_col_q <= 6'd5;
			start_row_q <= 5'd2;
			end_col_q <= 6'd10;
			end_row_q <= 5'd19;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_data[5:0];
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				REG_START_COL: start_col_q <= cfg_data[5:0];
				REG_START_ROW: start_row_q <= cfg_data[4:0];
				REG_END_COL: end_col_q <= cfg_data[5:0];
				REG_END_ROW: end_row_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			path_done_q <= 1'b1;
			cursor_q <= {5'd19, 6'd10};
			v_s1 <= 1'b0;
			found_q <= 1'b0;
			clr_q <= '0;
			sr_q <= '0;
			sc_q <= '0;
			nb_q <= '0;
			bd_q <= '0;
			best_q <= '0;
			bpar_q <= DIR_NONE;
		end else begin
			if ((state_q == ST_FIN || state_q == ST_POUT) && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (take) begin
				bd_q <= {1'b0, node_rd.distance};
				best_q <= addr_s1;
				bpar_q <= node_rd.parent;
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd.action == ACT_RUN) begin
						clr_q <= '0;
						state_q <= ST_CLR;
					end else if (accept && cmd.action == ACT_PATH && !path_done_q) begin
						state_q <= ST_PRD;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_SRC;
					end
				end
				ST_SRC: begin
					sr_q <= '0;
					sc_q <= '0;
					bd_q <= {1'b1, {DIST_W{1'b0}}};
					found_q <= 1'b0;
					v_s1 <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					v_s1 <= 1'b1;
					if (scan_last) begin
						state_q <= ST_SCANW;
					end else if ({1'b0, sc_q} == cols - 7'd1) begin
						sc_q <= '0;
						sr_q <= sr_q + ROW_W'(1);
					end else begin
						sc_q <= sc_q + COL_W'(1);
					end
				end
				ST_SCANW: begin
					v_s1 <= 1'b0;
					state_q <= (found_q || take) ? ST_MARK : ST_FINRD;
				end
				ST_MARK: begin
					nb_q <= '0;
					state_q <= ST_NBRD;
				end
				ST_NBRD, ST_NBWR: begin
					if (state_q == ST_NBRD && nb_ok) begin
						state_q <= ST_NBWR;
					end else if (nb_q == 2'd3) begin
						sr_q <= '0;
						sc_q <= '0;
						bd_q <= {1'b1, {DIST_W{1'b0}}};
						found_q <= 1'b0;
						v_s1 <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						nb_q <= nb_q + 2'd1;
						state_q <= ST_NBRD;
					end
				end
				ST_FINRD: state_q <= ST_FIN;
				ST_FIN: begin
					if (slot_free) begin
						cursor_q <= dst;
						path_done_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_PRD: state_q <= ST_POUT;
				ST_POUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						if (node_rd.parent == DIR_NORTH && pr != '0) begin
							cursor_q <= cursor_q - IDX_W'(MAX_COLS);
						end else if (node_rd.parent == DIR_EAST && pc != '1) begin
							cursor_q <= cursor_q + IDX_W'(1);
						end else if (node_rd.parent == DIR_SOUTH && pr != '1) begin
							cursor_q <= cursor_q + IDX_W'(MAX_COLS);
						end else if (node_rd.parent == DIR_WEST && pc != '0) begin
							cursor_q <= cursor_q - IDX_W'(1);
						end else begin
							path_done_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= {sr_q, sc_q};
		if (state_q == ST_FIN && slot_free) begin
			res_q <= res_t'{result_kind: RES_SEARCH, total_cost: node_rd.distance,
				path_col: '0, path_row: '0, last_cell: 1'b0};
		end else if (state_q == ST_POUT && slot_free) begin
			res_q <= res_t'{result_kind: RES_PATH, total_cost: node_rd.distance,
				path_col: pc, path_row: pr,
				last_cell: !((node_rd.parent == DIR_NORTH && pr != '0)
					|| (node_rd.parent == DIR_EAST && pc != '1)
					|| (node_rd.parent == DIR_SOUTH && pr != '1)
					|| (node_rd.parent == DIR_WEST && pc != '0))};
		end
	end
endmodule
